// ----- rtl/jch_pkg.sv -----
// Package for the jump consistent hash unit: shared constants, the controller state type,
// the multiplier operand select and the command and status structs.
// Depends on nothing; every other file in rtl uses it.
`default_nettype none

package jch_pkg;

  localparam int BUCKET_BITS_DEFAULT = 24;
  localparam logic [63:0] LCG_MULT = 64'h27BB2EE687B0B0FD;
  localparam int KEY_SHIFT = 33;
  localparam int SCALE_SHIFT = 31;
  localparam int DIV_W = 64 - KEY_SHIFT + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_KEY,
    S_CMP,
    S_TEST,
    S_DIV
  } state_t;

  typedef enum logic [1:0] {
    MSEL_KLO_MLO,
    MSEL_KHI_MLO,
    MSEL_KLO_MHI,
    MSEL_CNT_DIV
  } mul_sel_t;

  typedef struct packed {
    logic     load_key;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     save_lo;
    logic     save_hi;
    logic     key_step;
    logic     div_load;
    logic     div_step;
    logic     emit_zero;
    logic     emit_answer;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic stop;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/jump_consistent_hash_unit.sv -----
// Top level of the jump consistent hash unit: joins controller and datapath.
// Depends on jch_pkg, jch_ctrl and jch_dp.
`default_nettype none

// Maps a 64-bit key to a bucket index below the configured bucket count.
// Input: a key transaction is accepted on a rising edge with start high and busy low.
// Output: each result is shown for exactly one cycle with done high, carrying
// bucket_index and no_buckets; the receiver cannot stall the block, so no result waits.
// Configuration: bucket_count is written on any edge with cfg_write high; the user
// must write it only while idle; the block does not enforce this. Counts above
// 2^BUCKET_BITS are treated as 2^BUCKET_BITS; a count of zero gives no_buckets high and
// index zero in the cycle after acceptance, with busy staying low. Otherwise each jump
// runs S_MUL0, S_MUL1 and S_MUL2 (three multiplies on the shared 32x32 multiplier for
// the congruential key step), S_KEY for the key add, S_CMP and S_TEST for the multiply
// and compare of the bucket test, then S_DIV, the one-bit-a-cycle restoring divider.
// The final jump ends after S_TEST with done; there are about ln(bucket count) jumps per key.
// One key is worked on at a time; the next can be accepted in the cycle done is high.
// Reset sets the bucket count to one, returns the controller to idle and drops done.

module jump_consistent_hash_unit #(
  parameter int BUCKET_BITS = jch_pkg::BUCKET_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output wire logic                   busy,
  input  wire logic [63:0]            key_value,
  input  wire logic                   cfg_write,
  input  wire logic [BUCKET_BITS:0]   bucket_count,
  output wire logic                   done,
  output wire logic [BUCKET_BITS-1:0] bucket_index,
  output wire logic                   no_buckets
);

  jch_pkg::cmd_t    cmd;
  jch_pkg::status_t status;

  jch_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  jch_dp #(
    .BUCKET_BITS (BUCKET_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .key_value    (key_value),
    .cfg_write    (cfg_write),
    .bucket_count (bucket_count),
    .cmd          (cmd),
    .status       (status),
    .bucket_index (bucket_index),
    .no_buckets   (no_buckets)
  );

endmodule

`default_nettype wire

// ----- rtl/jch_ctrl.sv -----
// Controller state machine of the jump consistent hash unit.
// Sequences the shared multiplier, the bucket test and the divider; uses jch_pkg.
`default_nettype none

module jch_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  var  jch_pkg::status_t status,
  output var  jch_pkg::cmd_t    cmd,
  output wire logic            busy,
  output var  logic            done
);

  jch_pkg::state_t state;
  jch_pkg::state_t state_next;
  logic            done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jch_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      jch_pkg::S_IDLE: begin
        if (start && !status.count_zero) begin
          state_next = jch_pkg::S_MUL0;
        end
      end
      jch_pkg::S_MUL0: state_next = jch_pkg::S_MUL1;
      jch_pkg::S_MUL1: state_next = jch_pkg::S_MUL2;
      jch_pkg::S_MUL2: state_next = jch_pkg::S_KEY;
      jch_pkg::S_KEY:  state_next = jch_pkg::S_CMP;
      jch_pkg::S_CMP:  state_next = jch_pkg::S_TEST;
      jch_pkg::S_TEST: begin
        state_next = status.stop ? jch_pkg::S_IDLE : jch_pkg::S_DIV;
      end
      jch_pkg::S_DIV: begin
        if (status.div_last) begin
          state_next = jch_pkg::S_MUL0;
        end
      end
      default: state_next = jch_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = jch_pkg::MSEL_KLO_MLO;
    case (state)
      jch_pkg::S_IDLE: begin
        if (start) begin
          cmd.emit_zero = status.count_zero;
          cmd.load_key  = !status.count_zero;
        end
      end
      jch_pkg::S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = jch_pkg::MSEL_KLO_MLO;
      end
      jch_pkg::S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = jch_pkg::MSEL_KHI_MLO;
        cmd.save_lo = 1'b1;
      end
      jch_pkg::S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = jch_pkg::MSEL_KLO_MHI;
        cmd.save_hi = 1'b1;
      end
      jch_pkg::S_KEY: begin
        cmd.key_step = 1'b1;
      end
      jch_pkg::S_CMP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = jch_pkg::MSEL_CNT_DIV;
      end
      jch_pkg::S_TEST: begin
        cmd.emit_answer = status.stop;
        cmd.div_load    = !status.stop;
      end
      jch_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  assign done_next = cmd.emit_zero | cmd.emit_answer;
  assign busy      = (state != jch_pkg::S_IDLE);

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == jch_pkg::S_IDLE || $past(state) == jch_pkg::S_TEST))
    else $error("Result strobe raised outside the idle or test state.");

  a_div_return: assert property (@(posedge clk) disable iff (rst)
    (state == jch_pkg::S_DIV && status.div_last) |=> (state == jch_pkg::S_MUL0))
    else $error("Divider did not hand back to the key update.");

  a_start_work: assert property (@(posedge clk) disable iff (rst)
    (state == jch_pkg::S_IDLE && start && !status.count_zero) |=>
      (state == jch_pkg::S_MUL0 && !done))
    else $error("Accepted key did not start the iteration.");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (state == jch_pkg::S_IDLE && start && status.count_zero) |=>
      (state == jch_pkg::S_IDLE && done))
    else $error("Empty bucket set did not give an immediate result.");

endmodule

`default_nettype wire

// ----- rtl/jch_dp.sv -----
// Datapath of the jump consistent hash unit: key register, shared 32x32 multiplier,
// bucket test, restoring divider, count register and result registers; uses jch_pkg.
`default_nettype none

module jch_dp #(
  parameter int BUCKET_BITS = jch_pkg::BUCKET_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [63:0]            key_value,
  input  wire logic                   cfg_write,
  input  wire logic [BUCKET_BITS:0]   bucket_count,
  input  var  jch_pkg::cmd_t          cmd,
  output var  jch_pkg::status_t       status,
  output var  logic [BUCKET_BITS-1:0] bucket_index,
  output var  logic                   no_buckets
);

  localparam int NW = BUCKET_BITS + 1 + jch_pkg::SCALE_SHIFT;
  localparam int CW = $clog2(BUCKET_BITS + 1);
  localparam logic [BUCKET_BITS:0] LIMIT = {1'b1, {BUCKET_BITS{1'b0}}};

  logic [63:0]                key;
  logic [BUCKET_BITS-1:0]     answer;
  logic [63:0]                prod;
  logic [63:0]                lo_prod;
  logic [31:0]                hi_part;
  logic [jch_pkg::DIV_W-1:0]  rem;
  logic [BUCKET_BITS-1:0]     dividend;
  logic [CW-1:0]              div_cnt;
  logic [BUCKET_BITS:0]       count;

  logic [BUCKET_BITS:0]       count_eff;
  logic [jch_pkg::DIV_W-1:0]  divisor;
  logic [BUCKET_BITS:0]       aplus;
  logic [NW-1:0]              numer;
  logic [31:0]                op_a;
  logic [31:0]                op_b;
  logic [jch_pkg::DIV_W:0]    trial;
  logic                       ge;
  logic [jch_pkg::DIV_W-1:0]  rem_next;
  logic [BUCKET_BITS-1:0]     dividend_next;
  logic [31:0]                hi_sum;

  assign count_eff = (count > LIMIT) ? LIMIT : count;
  assign divisor   = jch_pkg::DIV_W'(key >> jch_pkg::KEY_SHIFT) + jch_pkg::DIV_W'(1);
  assign aplus     = {1'b0, answer} + (BUCKET_BITS + 1)'(1);
  assign numer     = {aplus, {jch_pkg::SCALE_SHIFT{1'b0}}};

  always_comb begin
    case (cmd.mul_sel)
      jch_pkg::MSEL_KLO_MLO: begin
        op_a = key[31:0];
        op_b = jch_pkg::LCG_MULT[31:0];
      end
      jch_pkg::MSEL_KHI_MLO: begin
        op_a = key[63:32];
        op_b = jch_pkg::LCG_MULT[31:0];
      end
      jch_pkg::MSEL_KLO_MHI: begin
        op_a = key[31:0];
        op_b = jch_pkg::LCG_MULT[63:32];
      end
      jch_pkg::MSEL_CNT_DIV: begin
        op_a = 32'(count_eff);
        op_b = 32'(divisor);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign trial         = {rem, dividend[BUCKET_BITS-1]};
  assign ge            = (trial >= {1'b0, divisor});
  assign rem_next      = ge ? jch_pkg::DIV_W'(trial - {1'b0, divisor})
                            : jch_pkg::DIV_W'(trial);
  assign dividend_next = (dividend << 1) | BUCKET_BITS'(ge);
  assign hi_sum        = hi_part + prod[31:0];

  assign status.count_zero = (count_eff == '0);
  assign status.stop       = (64'(numer) >= prod);
  assign status.div_last   = (div_cnt == CW'(BUCKET_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= (BUCKET_BITS + 1)'(1);
    end else if (cfg_write) begin
      count <= bucket_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key    <= key_value;
      answer <= '0;
    end else if (cmd.key_step) begin
      key <= lo_prod + {hi_sum, 32'd0} + 64'd1;
    end
    if (cmd.mul_en) begin
      prod <= op_a * op_b;
    end
    if (cmd.save_lo) begin
      lo_prod <= prod;
    end
    if (cmd.save_hi) begin
      hi_part <= prod[31:0];
    end
    if (cmd.div_load) begin
      rem      <= jch_pkg::DIV_W'(numer >> BUCKET_BITS);
      dividend <= numer[BUCKET_BITS-1:0];
      div_cnt  <= '0;
    end else if (cmd.div_step) begin
      rem      <= rem_next;
      dividend <= dividend_next;
      div_cnt  <= div_cnt + CW'(1);
      if (status.div_last) begin
        answer <= dividend_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_index <= '0;
      no_buckets   <= 1'b0;
    end else if (cmd.emit_zero) begin
      bucket_index <= '0;
      no_buckets   <= 1'b1;
    end else if (cmd.emit_answer) begin
      bucket_index <= answer;
      no_buckets   <= 1'b0;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < divisor))
    else $error("Partial remainder is not below the divisor.");

  a_empty_index: assert property (@(posedge clk) disable iff (rst)
    no_buckets |-> (bucket_index == '0))
    else $error("Empty bucket set reported with a non-zero index.");

  a_key_stable: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.div_step) |-> $stable(key))
    else $error("Key changed during division.");

endmodule

`default_nettype wire
